/* hdl/b2da_pkg.sv */
package b2da_pkg;

	localparam logic [5:0] ASCII_ZERO = 6'd48;

	localparam logic [1:0] STEP_IDLE = 2'd0;
	localparam logic [1:0] STEP_DABBLE = 2'd1;
	localparam logic [1:0] STEP_SKIP = 2'd2;
	localparam logic [1:0] STEP_EMIT = 2'd3;

	localparam logic [1:0] COND_IN_XFER = 2'd0;
	localparam logic [1:0] COND_BITS_LAST = 2'd1;
	localparam logic [1:0] COND_LEAD_DONE = 2'd2;
	localparam logic [1:0] COND_OUT_LAST = 2'd3;

	typedef struct packed {
		logic [1:0] cond;
		logic [1:0] target;
		logic       accept;
		logic       dabble;
		logic       skip;
		logic       emit;
	} uword_t;

	typedef struct packed {
		logic load;
		logic dabble;
		logic shift;
	} ctrl_t;

	typedef struct packed {
		logic bits_last;
		logic top_zero;
		logic cnt_zero;
	} status_t;

	function automatic uword_t ucode(input logic [1:0] step);
		uword_t w;
		w = '0;
		unique case (step)
			STEP_IDLE: begin
				w.cond = COND_IN_XFER;
				w.target = STEP_DABBLE;
				w.accept = 1'b1;
			end
			STEP_DABBLE: begin
				w.cond = COND_BITS_LAST;
				w.target = STEP_SKIP;
				w.dabble = 1'b1;
			end
			STEP_SKIP: begin
				w.cond = COND_LEAD_DONE;
				w.target = STEP_EMIT;
				w.skip = 1'b1;
			end
			STEP_EMIT: begin
				w.cond = COND_OUT_LAST;
				w.target = STEP_IDLE;
				w.emit = 1'b1;
			end
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

/* hdl/b2da_dpath.sv */
module b2da_dpath
	import b2da_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_t                 ctrl,
	input  logic [VALUE_BITS-1:0] value_in,
	output status_t               status,
	output logic [5:0]            digit_char
);

	localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BCD_W = DIGITS * 4;
	localparam int BC_W = $clog2(VALUE_BITS + 1);
	localparam int DC_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

	logic [VALUE_BITS-1:0] bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [BCD_W-1:0]      bcd_adj;
	logic [BC_W-1:0]       bit_cnt_q;
	logic [DC_W-1:0]       dig_cnt_q;
	logic [3:0]            top_digit;

	always_comb begin
		for (int i = 0; i < DIGITS; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			bin_q <= value_in;
			bcd_q <= '0;
		end else if (ctrl.dabble) begin
			bin_q <= {bin_q[VALUE_BITS-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_BITS-1]};
		end else if (ctrl.shift) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
		end else if (ctrl.load) begin
			bit_cnt_q <= BC_W'(VALUE_BITS);
			dig_cnt_q <= DC_W'(DIGITS - 1);
		end else begin
			if (ctrl.dabble) begin
				bit_cnt_q <= bit_cnt_q - 1'b1;
			end
			if (ctrl.shift && dig_cnt_q != '0) begin
				dig_cnt_q <= dig_cnt_q - 1'b1;
			end
		end
	end

	assign top_digit = bcd_q[BCD_W-1 -: 4];
	assign digit_char = ASCII_ZERO + {2'b00, top_digit};
	assign status.bits_last = (bit_cnt_q == BC_W'(1));
	assign status.top_zero = (top_digit == 4'd0);
	assign status.cnt_zero = (dig_cnt_q == '0);

endmodule

/* hdl/binary_to_decimal_ascii.sv */
// Channel   Dir  Payload                                   Item
// s_axis    in   tdata[VALUE_BITS-1:0] value               one number
// m_axis    out  tdata[5:0] digit_char, tlast last_digit   one digit character
//
// An item passes through the accept step, one double dabble step per input
// bit, a pass over the leading zero digits and an emit step per emitted digit,
// all run by the step table.
// One item is in work at a time; s_axis_tready is high only in the idle step.
// A stall on m_axis holds the current digit until it is taken.
// Reset returns the step counter to idle; no result is pending after reset.
module binary_to_decimal_ascii
	import b2da_pkg::*;
#(
	parameter int VALUE_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// value
	input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// digit_char, then zero fill
	output logic [7:0]                        m_axis_tdata,
	output logic                              m_axis_tlast
);

	logic [1:0] pc_q;
	uword_t     uw;
	status_t    status;
	ctrl_t      ctrl;
	logic [5:0] digit_char;
	logic       cond;
	logic       in_xfer;
	logic       out_xfer;

	assign uw = ucode(pc_q);
	assign s_axis_tready = uw.accept;
	assign m_axis_tvalid = uw.emit;
	assign in_xfer = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_comb begin
		unique case (uw.cond)
			COND_IN_XFER: cond = in_xfer;
			COND_BITS_LAST: cond = status.bits_last;
			COND_LEAD_DONE: cond = !status.top_zero || status.cnt_zero;
			COND_OUT_LAST: cond = out_xfer && status.cnt_zero;
			default: cond = 1'b0;
		endcase
	end

	assign ctrl.load = uw.accept && in_xfer;
	assign ctrl.dabble = uw.dabble;
	assign ctrl.shift = (uw.skip && !cond) || (uw.emit && out_xfer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_IDLE;
		end else if (cond) begin
			pc_q <= uw.target;
		end
	end

	b2da_dpath #(
		.VALUE_BITS(VALUE_BITS)
	) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl(ctrl),
		.value_in(s_axis_tdata[VALUE_BITS-1:0]),
		.status(status),
		.digit_char(digit_char)
	);

	assign m_axis_tdata = {2'b00, digit_char};
	assign m_axis_tlast = status.cnt_zero;

`ifndef SYNTHESIS
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + 6'd9))
		else $error("digit out of range");
	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("input accepted while a digit is pending");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_xfer && m_axis_tlast) |=> s_axis_tready)
		else $error("sequencer did not return to idle after last digit");
	a_first_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_SKIP && cond && !status.cnt_zero) |-> !status.top_zero)
		else $error("leading zero reached emission");
`endif

endmodule
